// ===== rtl/core/chroma_key_blend_defines.svh =====
// ----------------------------------------------------------------------------
// chroma_key_blend_defines.svh
// Assertion macros shared by the chroma key blend checker.
// ----------------------------------------------------------------------------
`ifndef CHROMA_KEY_BLEND_DEFINES_SVH
`define CHROMA_KEY_BLEND_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define CKB_ASSERT_SAME(label, cond_a, cond_b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond_a) |-> (cond_b)) \
        else $error("chroma_key_blend: same-cycle check failed");

// next-cycle implication, sampled on clk, off during reset
`define CKB_ASSERT_NEXT(label, cond_a, cond_b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond_a) |=> (cond_b)) \
        else $error("chroma_key_blend: next-cycle check failed");

`endif

// ===== rtl/core/ckb_pkg.sv =====
// ----------------------------------------------------------------------------
// ckb_pkg
// Types, constants and helper functions for the chroma key blend pipeline.
// ----------------------------------------------------------------------------
package ckb_pkg;

    localparam int PIX_W      = 8;
    localparam int SQ_W       = 2 * PIX_W;
    localparam int SUM_W      = 18;
    localparam int DIST_W     = 9;
    localparam int REM_W      = 10;
    localparam int TRIAL_W    = REM_W + 2;
    localparam int CFG_W      = 9;
    localparam int CFG_IDX_W  = 3;
    localparam int STEPS_PER_STAGE = 3;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_RED   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_GREEN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_BLUE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LOWER     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UPPER     = 3'd4;

    typedef enum logic [1:0] {
        REGION_BG    = 2'd0,
        REGION_BLEND = 2'd1,
        REGION_FG    = 2'd2
    } region_t;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } pixel_t;

    typedef struct packed {
        pixel_t fg;
        pixel_t bg;
    } pair_t;

    // digit-by-digit square root state: radicand bits still to bring down,
    // partial remainder and partial root
    typedef struct packed {
        logic [SUM_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [DIST_W-1:0] root;
    } sqrt_t;

    function automatic logic [PIX_W-1:0] abs_diff(input logic [PIX_W-1:0] a,
                                                  input logic [PIX_W-1:0] b);
        logic [PIX_W-1:0] d;
        if (a > b)
        begin
            d = a - b;
        end
        else
        begin
            d = b - a;
        end
        return d;
    endfunction

    // one root bit: bring down two radicand bits, trial subtract 4*root+1
    function automatic sqrt_t sqrt_step(input sqrt_t s);
        logic [TRIAL_W-1:0] trial_rem;
        logic [TRIAL_W-1:0] trial_sub;
        sqrt_t              r;
        trial_rem = {s.rem, s.rad[SUM_W-1 -: 2]};
        trial_sub = {1'b0, s.root, 2'b01};
        r.rad     = {s.rad[SUM_W-3:0], 2'b00};
        if (trial_rem >= trial_sub)
        begin
            r.rem  = REM_W'(trial_rem - trial_sub);
            r.root = {s.root[DIST_W-2:0], 1'b1};
        end
        else
        begin
            r.rem  = REM_W'(trial_rem);
            r.root = {s.root[DIST_W-2:0], 1'b0};
        end
        return r;
    endfunction

    function automatic logic [PIX_W-1:0] avg2(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b);
        logic [PIX_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[PIX_W:1];
    endfunction

endpackage

// ===== rtl/core/ckb_dist.sv =====
// ----------------------------------------------------------------------------
// ckb_dist
// Squared key distance: abs difference, square and sum, three stages.
// ----------------------------------------------------------------------------
module ckb_dist (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ckb_pkg::pixel_t      key,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  ckb_pkg::pair_t       in_pair,
    output logic                 out_valid,
    input  logic                 out_ready,
    output ckb_pkg::pair_t       out_pair,
    output logic [ckb_pkg::SUM_W-1:0] out_sum
);
    import ckb_pkg::*;

    logic   a_valid_reg, b_valid_reg, c_valid_reg;
    logic   a_ready, b_ready, c_ready;
    pair_t  a_pair_reg, b_pair_reg, c_pair_reg;
    logic [PIX_W-1:0] dr_reg, dg_reg, db_reg;
    logic [SQ_W-1:0]  sr_reg, sg_reg, sb_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [SUM_W-1:0] sum_next;

    assign c_ready  = !c_valid_reg || out_ready;
    assign b_ready  = !b_valid_reg || c_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    assign sum_next = SUM_W'(sr_reg) + SUM_W'(sg_reg) + SUM_W'(sb_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= in_valid;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_ready)
            begin
                c_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && in_valid)
        begin
            a_pair_reg <= in_pair;
            dr_reg     <= abs_diff(in_pair.fg.red, key.red);
            dg_reg     <= abs_diff(in_pair.fg.green, key.green);
            db_reg     <= abs_diff(in_pair.fg.blue, key.blue);
        end
        if (b_ready && a_valid_reg)
        begin
            b_pair_reg <= a_pair_reg;
            sr_reg     <= SQ_W'(dr_reg) * SQ_W'(dr_reg);
            sg_reg     <= SQ_W'(dg_reg) * SQ_W'(dg_reg);
            sb_reg     <= SQ_W'(db_reg) * SQ_W'(db_reg);
        end
        if (c_ready && b_valid_reg)
        begin
            c_pair_reg <= b_pair_reg;
            sum_reg    <= sum_next;
        end
    end

    assign out_valid = c_valid_reg;
    assign out_pair  = c_pair_reg;
    assign out_sum   = sum_reg;

endmodule

// ===== rtl/core/ckb_sqrt_stage.sv =====
// ----------------------------------------------------------------------------
// ckb_sqrt_stage
// One register stage of the integer square root, three root bits per stage.
// ----------------------------------------------------------------------------
module ckb_sqrt_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  ckb_pkg::pair_t   in_pair,
    input  ckb_pkg::sqrt_t   in_sqrt,
    output logic             out_valid,
    input  logic             out_ready,
    output ckb_pkg::pair_t   out_pair,
    output ckb_pkg::sqrt_t   out_sqrt
);
    import ckb_pkg::*;

    logic  valid_reg;
    pair_t pair_reg;
    sqrt_t sqrt_reg;
    sqrt_t sqrt_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        sqrt_next = in_sqrt;
        for (int k = 0; k < STEPS_PER_STAGE; k++)
        begin
            sqrt_next = sqrt_step(sqrt_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            pair_reg <= in_pair;
            sqrt_reg <= sqrt_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_pair  = pair_reg;
    assign out_sqrt  = sqrt_reg;

endmodule

// ===== rtl/core/ckb_select.sv =====
// ----------------------------------------------------------------------------
// ckb_select
// Threshold compare and pixel select/average; holds the output word.
// ----------------------------------------------------------------------------
module ckb_select (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [ckb_pkg::CFG_W-1:0]  lower,
    input  logic [ckb_pkg::CFG_W-1:0]  upper,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  ckb_pkg::pair_t             in_pair,
    input  logic [ckb_pkg::DIST_W-1:0] in_dist,
    output logic                       out_valid,
    input  logic                       out_ready,
    output ckb_pkg::pixel_t            out_pix,
    output ckb_pkg::region_t           out_region
);
    import ckb_pkg::*;

    logic    valid_reg;
    pixel_t  pix_reg, pix_next;
    region_t region_reg, region_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        if (in_dist < lower)
        begin
            region_next = REGION_BG;
            pix_next    = in_pair.bg;
        end
        else if (in_dist > upper)
        begin
            region_next = REGION_FG;
            pix_next    = in_pair.fg;
        end
        else
        begin
            region_next    = REGION_BLEND;
            pix_next.red   = avg2(in_pair.fg.red, in_pair.bg.red);
            pix_next.green = avg2(in_pair.fg.green, in_pair.bg.green);
            pix_next.blue  = avg2(in_pair.fg.blue, in_pair.bg.blue);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            pix_reg    <= pix_next;
            region_reg <= region_next;
        end
    end

    assign out_valid  = valid_reg;
    assign out_pix    = pix_reg;
    assign out_region = region_reg;

endmodule

// ===== rtl/core/chroma_key_blend.sv =====
// ----------------------------------------------------------------------------
// chroma_key_blend
// Chroma key compositing of one foreground/background pixel pair per word.
//
// Input channel: in_valid/in_stall with fg_* and bg_* pixel channels.
// Output channel: out_valid/out_stall with out_red/green/blue and region
// (0 background, 1 blend, 2 foreground).
// Config: cfg_write, cfg_index, cfg_data; index 0..2 key color, 3 lower
// threshold, 4 upper threshold, other indexes ignored. Write while idle.
// Pipeline: 3 stages distance (diff, square, sum), 3 stages square
// root (3 root bits each), 1 stage compare/select which is the output
// register.
// Throughput: one word per cycle unless stalled; no state links words.
// Stall: each stage loads when empty or when the next one loads, so a
// stalled output fills the pipeline before in_stall rises; bubbles are
// squeezed out and no word is lost or repeated.
// Reset: all stages empty, all config registers zero.
// ----------------------------------------------------------------------------
module chroma_key_blend (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [ckb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ckb_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [ckb_pkg::PIX_W-1:0]     fg_red,
    input  logic [ckb_pkg::PIX_W-1:0]     fg_green,
    input  logic [ckb_pkg::PIX_W-1:0]     fg_blue,
    input  logic [ckb_pkg::PIX_W-1:0]     bg_red,
    input  logic [ckb_pkg::PIX_W-1:0]     bg_green,
    input  logic [ckb_pkg::PIX_W-1:0]     bg_blue,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [ckb_pkg::PIX_W-1:0]     out_red,
    output logic [ckb_pkg::PIX_W-1:0]     out_green,
    output logic [ckb_pkg::PIX_W-1:0]     out_blue,
    output logic [1:0]                    region
);
    import ckb_pkg::*;

    pixel_t            key_reg;
    logic [CFG_W-1:0]  lower_reg, upper_reg;

    pair_t             in_pair;
    logic              dist_in_ready;
    logic              d_valid, d_ready;
    pair_t             d_pair;
    logic [SUM_W-1:0]  d_sum;
    sqrt_t             s0_sqrt;

    logic              s1_valid, s1_ready, s2_valid, s2_ready, s3_valid, s3_ready;
    pair_t             s1_pair, s2_pair, s3_pair;
    sqrt_t             s1_sqrt, s2_sqrt, s3_sqrt;

    pixel_t            sel_pix;
    region_t           sel_region;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg   <= '0;
            lower_reg <= '0;
            upper_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_KEY_RED:   key_reg.red   <= cfg_data[PIX_W-1:0];
                REG_KEY_GREEN: key_reg.green <= cfg_data[PIX_W-1:0];
                REG_KEY_BLUE:  key_reg.blue  <= cfg_data[PIX_W-1:0];
                REG_LOWER:     lower_reg     <= cfg_data;
                REG_UPPER:     upper_reg     <= cfg_data;
                default:       ;
            endcase
        end
    end

    assign in_pair.fg.red   = fg_red;
    assign in_pair.fg.green = fg_green;
    assign in_pair.fg.blue  = fg_blue;
    assign in_pair.bg.red   = bg_red;
    assign in_pair.bg.green = bg_green;
    assign in_pair.bg.blue  = bg_blue;
    assign in_stall         = !dist_in_ready;

    ckb_dist u_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .key       (key_reg),
        .in_valid  (in_valid),
        .in_ready  (dist_in_ready),
        .in_pair   (in_pair),
        .out_valid (d_valid),
        .out_ready (d_ready),
        .out_pair  (d_pair),
        .out_sum   (d_sum)
    );

    assign s0_sqrt.rad  = d_sum;
    assign s0_sqrt.rem  = '0;
    assign s0_sqrt.root = '0;

    ckb_sqrt_stage u_sqrt0 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (d_valid),
        .in_ready  (d_ready),
        .in_pair   (d_pair),
        .in_sqrt   (s0_sqrt),
        .out_valid (s1_valid),
        .out_ready (s1_ready),
        .out_pair  (s1_pair),
        .out_sqrt  (s1_sqrt)
    );

    ckb_sqrt_stage u_sqrt1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid),
        .in_ready  (s1_ready),
        .in_pair   (s1_pair),
        .in_sqrt   (s1_sqrt),
        .out_valid (s2_valid),
        .out_ready (s2_ready),
        .out_pair  (s2_pair),
        .out_sqrt  (s2_sqrt)
    );

    ckb_sqrt_stage u_sqrt2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid),
        .in_ready  (s2_ready),
        .in_pair   (s2_pair),
        .in_sqrt   (s2_sqrt),
        .out_valid (s3_valid),
        .out_ready (s3_ready),
        .out_pair  (s3_pair),
        .out_sqrt  (s3_sqrt)
    );

    ckb_select u_select (
        .clk        (clk),
        .rst_n      (rst_n),
        .lower      (lower_reg),
        .upper      (upper_reg),
        .in_valid   (s3_valid),
        .in_ready   (s3_ready),
        .in_pair    (s3_pair),
        .in_dist    (s3_sqrt.root),
        .out_valid  (out_valid),
        .out_ready  (!out_stall),
        .out_pix    (sel_pix),
        .out_region (sel_region)
    );

    assign out_red   = sel_pix.red;
    assign out_green = sel_pix.green;
    assign out_blue  = sel_pix.blue;
    assign region    = sel_region;

endmodule

// ===== rtl/core/ckb_checker.sv =====
// ----------------------------------------------------------------------------
// ckb_checker
// Port-level checks for chroma_key_blend, bound to the top level.
// ----------------------------------------------------------------------------
`include "chroma_key_blend_defines.svh"

module ckb_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [ckb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ckb_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          in_stall,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic [ckb_pkg::PIX_W-1:0]     out_red,
    input  logic [ckb_pkg::PIX_W-1:0]     out_green,
    input  logic [ckb_pkg::PIX_W-1:0]     out_blue,
    input  logic [1:0]                    region
);
    import ckb_pkg::*;

    // shadow of the lower threshold, seen from the config port
    logic [CFG_W-1:0] lower_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_reg <= '0;
        end
        else if (cfg_write && cfg_index == REG_LOWER)
        begin
            lower_reg <= cfg_data;
        end
    end

    // stalled output word holds
    `CKB_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
        out_valid && $stable(out_red) && $stable(out_green) && $stable(out_blue)
        && $stable(region))

    // a free-running output means every stage can load
    `CKB_ASSERT_SAME(a_no_in_stall, !out_stall, !in_stall)

    // background needs a distance below the lower threshold
    `CKB_ASSERT_SAME(a_bg_needs_lower, out_valid && region == REGION_BG, lower_reg != '0)

    `CKB_ASSERT_SAME(a_region_code, out_valid,
        region == REGION_BG || region == REGION_BLEND || region == REGION_FG)

endmodule

bind chroma_key_blend ckb_checker u_ckb_checker (.*);

// ===== tb/tb_chroma_key_blend.sv =====
// ----------------------------------------------------------------------------
// tb_chroma_key_blend
// Self-checking bench for the chroma key compositor. A scoreboard class
// predicts each composited word from its own copy of the key color and the
// thresholds, using an exact squared distance and an integer square root.
// Directed words cover the field extremes, distances equal to a threshold,
// crossed thresholds and ignored register indexes. Randomized phases then
// follow with fresh settings each, bursty input, a patterned output stall,
// and one long output hold-off that backs the pipeline up.
// ----------------------------------------------------------------------------
module tb_chroma_key_blend;

    import ckb_pkg::*;

    class blend_scoreboard;

        typedef struct packed {
            logic [7:0] red;
            logic [7:0] green;
            logic [7:0] blue;
            region_t    zone;
        } composite_t;

        logic [7:0] key_r;
        logic [7:0] key_g;
        logic [7:0] key_b;
        logic [8:0] lower_thr;
        logic [8:0] upper_thr;
        composite_t composite_q[$];
        int         errors;

        function new();
            key_r     = '0;
            key_g     = '0;
            key_b     = '0;
            lower_thr = '0;
            upper_thr = '0;
            errors    = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [8:0] data);
            case (idx)
                REG_KEY_RED:   key_r = data[7:0];
                REG_KEY_GREEN: key_g = data[7:0];
                REG_KEY_BLUE:  key_b = data[7:0];
                REG_LOWER:     lower_thr = data;
                REG_UPPER:     upper_thr = data;
                default:       ;
            endcase
        endfunction

        function int key_distance(int fr, int fgc, int fb);
            int dr;
            int dg;
            int db;
            int sum;
            int root;
            int cand;
            dr = fr - int'(key_r);
            dg = fgc - int'(key_g);
            db = fb - int'(key_b);
            sum = dr * dr + dg * dg + db * db;
            root = 0;
            for (int b = 8; b >= 0; b--)
            begin
                cand = root | (1 << b);
                if (cand * cand <= sum)
                begin
                    root = cand;
                end
            end
            return root;
        endfunction

        function void note_pixel(logic [7:0] fr, logic [7:0] fgc, logic [7:0] fb,
                                 logic [7:0] br, logic [7:0] bgc, logic [7:0] bb);
            int         key_dist;
            composite_t c;
            key_dist = key_distance(fr, fgc, fb);
            if (key_dist < int'(lower_thr))
            begin
                c = '{br, bgc, bb, REGION_BG};
            end
            else if (key_dist > int'(upper_thr))
            begin
                c = '{fr, fgc, fb, REGION_FG};
            end
            else
            begin
                c.red   = 8'((int'(fr) + int'(br)) >> 1);
                c.green = 8'((int'(fgc) + int'(bgc)) >> 1);
                c.blue  = 8'((int'(fb) + int'(bb)) >> 1);
                c.zone  = REGION_BLEND;
            end
            composite_q.push_back(c);
        endfunction

        function void compare_field(string label, int want, int got);
            if (want != got)
            begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                   logic [1:0] zone);
            composite_t c;
            if (composite_q.size() == 0)
            begin
                $display("%0t: unexpected word, expected none, actual %0d %0d %0d region %0d",
                         $time, r, g, b, zone);
                errors++;
                return;
            end
            c = composite_q.pop_front();
            compare_field("out_red", c.red, r);
            compare_field("out_green", c.green, g);
            compare_field("out_blue", c.blue, b);
            compare_field("region", int'(c.zone), zone);
        endfunction

        function int pending();
            return composite_q.size();
        endfunction

    endclass

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic [PIX_W-1:0]     fg_red;
    logic [PIX_W-1:0]     fg_green;
    logic [PIX_W-1:0]     fg_blue;
    logic [PIX_W-1:0]     bg_red;
    logic [PIX_W-1:0]     bg_green;
    logic [PIX_W-1:0]     bg_blue;
    logic                 out_valid;
    logic                 out_stall;
    logic [PIX_W-1:0]     out_red;
    logic [PIX_W-1:0]     out_green;
    logic [PIX_W-1:0]     out_blue;
    logic [1:0]           region;

    blend_scoreboard sb = new();
    int              burst_left = 0;
    bit              hold_req = 1'b0;

    chroma_key_blend u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .fg_red    (fg_red),
        .fg_green  (fg_green),
        .fg_blue   (fg_blue),
        .bg_red    (bg_red),
        .bg_green  (bg_green),
        .bg_blue   (bg_blue),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_red   (out_red),
        .out_green (out_green),
        .out_blue  (out_blue),
        .region    (region)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            sb.check_result(out_red, out_green, out_blue, region);
        end
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic push_pixel(input logic [7:0] fr, input logic [7:0] fgc,
                              input logic [7:0] fb, input logic [7:0] br,
                              input logic [7:0] bgc, input logic [7:0] bb);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        in_valid <= 1'b1;
        fg_red   <= fr;
        fg_green <= fgc;
        fg_blue  <= fb;
        bg_red   <= br;
        bg_green <= bgc;
        bg_blue  <= bb;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        sb.note_pixel(fr, fgc, fb, br, bgc, bb);
        burst_left--;
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0)
        begin
            @(negedge clk);
        end
    endtask

    // block must be idle; also writes one ignored index
    task automatic configure(input logic [8:0] kr, input logic [8:0] kg,
                             input logic [8:0] kb, input logic [8:0] lo,
                             input logic [8:0] hi);
        logic [2:0] idx[6];
        logic [8:0] val[6];
        idx = '{REG_KEY_RED, REG_KEY_GREEN, 3'($urandom_range(5, 7)), REG_KEY_BLUE,
                REG_LOWER, REG_UPPER};
        val = '{kr, kg, 9'($urandom_range(0, 511)), kb, lo, hi};
        for (int i = 0; i < 6; i++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge clk);
            sb.set_reg(idx[i], val[i]);
            @(negedge clk);
        end
        cfg_write <= 1'b0;
    endtask

    function automatic logic [7:0] near_key(logic [7:0] k);
        int v;
        v = int'(k) + $urandom_range(0, 48) - 24;
        if (v < 0)
        begin
            v = 0;
        end
        if (v > 255)
        begin
            v = 255;
        end
        return 8'(v);
    endfunction

    // output side: a changing random stall pattern, or a hold on request
    initial
    begin : out_side
        int cnt;
        int mode;
        cnt = 0;
        mode = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (90) @(negedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                if (cnt == 0)
                begin
                    mode = $urandom_range(0, 3);
                    cnt = $urandom_range(20, 200);
                end
                cnt--;
                case (mode)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(0, 3) == 0);
                    2:       out_stall <= $urandom_range(0, 1);
                    default: out_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    initial
    begin
        #3000000;
        $display("[chroma_key_blend] ERROR");
        $finish;
    end

    initial
    begin : stimulus
        int         mode;
        int         lo;
        int         hi;
        logic [7:0] fr;
        logic [7:0] fgc;
        logic [7:0] fb;
        rst_n     = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        fg_red    = '0;
        fg_green  = '0;
        fg_blue   = '0;
        bg_red    = '0;
        bg_green  = '0;
        bg_blue   = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: key black, both thresholds zero
        push_pixel(8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255);
        push_pixel(8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0);
        push_pixel(8'd1, 8'd0, 8'd0, 8'd10, 8'd20, 8'd30);
        drain();

        // distance equal to both thresholds; bit 8 of a key write is dropped
        configure(9'h100, 9'h100, 9'h100, 9'd5, 9'd5);
        push_pixel(8'd3, 8'd4, 8'd0, 8'd255, 8'd255, 8'd255);
        push_pixel(8'd0, 8'd0, 8'd0, 8'd17, 8'd34, 8'd51);
        push_pixel(8'd6, 8'd8, 8'd0, 8'd1, 8'd2, 8'd3);
        push_pixel(8'd2, 8'd2, 8'd2, 8'd200, 8'd100, 8'd50);
        push_pixel(8'd4, 8'd4, 8'd3, 8'd9, 8'd9, 8'd9);
        drain();

        // full-range blend window
        configure(9'd255, 9'd255, 9'd255, 9'd0, 9'd511);
        push_pixel(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
        push_pixel(8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255);
        push_pixel(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        push_pixel(8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd1);
        drain();

        // crossed thresholds: lower test wins
        configure(9'd0, 9'd0, 9'd0, 9'd300, 9'd100);
        push_pixel(8'd255, 8'd255, 8'd255, 8'd7, 8'd7, 8'd7);
        push_pixel(8'd100, 8'd100, 8'd100, 8'd8, 8'd8, 8'd8);
        push_pixel(8'd0, 8'd0, 8'd0, 8'd9, 8'd9, 8'd9);
        push_pixel(8'd180, 8'd180, 8'd180, 8'd10, 8'd10, 8'd10);
        drain();

        // both thresholds at maximum: background everywhere
        configure(9'd0, 9'd0, 9'd0, 9'd511, 9'd511);
        push_pixel(8'd255, 8'd255, 8'd255, 8'd0, 8'd128, 8'd255);
        push_pixel(8'd128, 8'd64, 8'd32, 8'd255, 8'd0, 8'd1);
        drain();

        for (int p = 0; p < 8; p++)
        begin
            mode = (p < 3) ? p : $urandom_range(0, 3);
            case (mode)
                1:
                begin
                    hi = $urandom_range(0, 200);
                    lo = hi + $urandom_range(1, 150);
                end
                2:
                begin
                    lo = $urandom_range(0, 1) * 511;
                    hi = $urandom_range(0, 1) * 511;
                end
                default:
                begin
                    lo = $urandom_range(0, 250);
                    hi = lo + $urandom_range(0, 200);
                end
            endcase
            configure(9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)),
                      9'($urandom_range(0, 511)), 9'(lo), 9'(hi));
            if (p == 1)
            begin
                hold_req = 1'b1;
            end
            repeat (135)
            begin
                if ($urandom_range(0, 2) == 0)
                begin
                    fr  = near_key(sb.key_r);
                    fgc = near_key(sb.key_g);
                    fb  = near_key(sb.key_b);
                end
                else
                begin
                    fr  = 8'($urandom);
                    fgc = 8'($urandom);
                    fb  = 8'($urandom);
                end
                push_pixel(fr, fgc, fb, 8'($urandom), 8'($urandom), 8'($urandom));
            end
            drain();
        end

        repeat (20) @(negedge clk);
        if (sb.errors == 0)
        begin
            $display("[chroma_key_blend] OK");
        end
        else
        begin
            $display("[chroma_key_blend] ERROR");
        end
        $finish;
    end

endmodule
